// ===== hdl/acr_pkg.sv =====
`timescale 1ns / 1ps
package acr_pkg;

  localparam logic [9:0] SCREEN_WIDTH  = 10'd480;
  localparam logic [9:0] SCREEN_HEIGHT = 10'd272;

  localparam logic [31:0] ALPHA_OPAQUE = 32'hFF00_0000;

  // configuration register indexes
  localparam logic [2:0] CFG_CENTER_X     = 3'd0;
  localparam logic [2:0] CFG_CENTER_Y     = 3'd1;
  localparam logic [2:0] CFG_ARC_RADIUS   = 3'd2;
  localparam logic [2:0] CFG_QUADRANT_SEL = 3'd3;
  localparam logic [2:0] CFG_OFFSET_MIN   = 3'd4;
  localparam logic [2:0] CFG_OFFSET_MAX   = 3'd5;
  localparam logic [2:0] CFG_DRAW_COLOR   = 3'd6;

  // quadrant codes
  localparam logic [1:0] QUAD_UPPER_RIGHT = 2'd0;
  localparam logic [1:0] QUAD_UPPER_LEFT  = 2'd1;
  localparam logic [1:0] QUAD_LOWER_LEFT  = 2'd2;
  localparam logic [1:0] QUAD_LOWER_RIGHT = 2'd3;

  // current walk point handed from the walker to the pixel stage
  typedef struct packed {
    logic       active;
    logic [9:0] x;
    logic [9:0] y;
    logic       done;
  } acr_walk_t;

endpackage

// ===== hdl/acr_place.sv =====
`timescale 1ns / 1ps
module acr_place (
  input  logic signed [10:0] center_x,
  input  logic signed [10:0] center_y,
  input  logic signed [9:0]  offset_min,
  input  logic signed [9:0]  offset_max,
  input  logic               enable,
  input  logic signed [10:0] dx,
  input  logic signed [10:0] dy,
  output logic               pix_valid,
  output logic [9:0]         pix_x,
  output logic [9:0]         pix_y
);
  import acr_pkg::*;

  logic signed [11:0] sx;
  logic signed [11:0] sy;
  logic [10:0]        sx_clamp;
  logic [10:0]        sy_clamp;
  logic               in_window;

  always_comb begin
    sx = {center_x[10], center_x} + {dx[10], dx};
    sy = {center_y[10], center_y} + {dy[10], dy};
    sx_clamp = sx[11] ? 11'd0 : sx[10:0];
    sy_clamp = sy[11] ? 11'd0 : sy[10:0];
    in_window = !(dx < $signed({offset_min[9], offset_min})) &&
                !(dx > $signed({offset_max[9], offset_max}));
    pix_valid = enable && in_window &&
                (sx_clamp < {1'b0, SCREEN_WIDTH}) && (sy_clamp < {1'b0, SCREEN_HEIGHT});
    pix_x = pix_valid ? sx_clamp[9:0] : 10'd0;
    pix_y = pix_valid ? sy_clamp[9:0] : 10'd0;
  end

endmodule

// ===== hdl/acr_walk.sv =====
`timescale 1ns / 1ps
module acr_walk (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic              restart,
  input  logic [8:0]        arc_radius,
  output acr_pkg::acr_walk_t pt
);
  import acr_pkg::*;

  logic [9:0]         walk_x;
  logic [9:0]         walk_y;
  logic signed [13:0] decision;

  logic [9:0]         walk_x_next;
  logic [9:0]         walk_y_next;
  logic signed [13:0] decision_next;

  logic [9:0]         cur_x;
  logic [9:0]         cur_y;
  logic signed [13:0] cur_d;
  logic signed [10:0] diff_xy;
  logic               active;

  always_comb begin
    // restart takes effect before this item's iteration
    cur_x = restart ? 10'd0 : walk_x;
    cur_y = restart ? {1'b0, arc_radius} : walk_y;
    cur_d = restart ? (14'sd3 - $signed({4'b0, arc_radius, 1'b0})) : decision;
    active = cur_x <= cur_y;
    diff_xy = $signed({1'b0, cur_x}) - $signed({1'b0, cur_y});

    walk_x_next = cur_x;
    walk_y_next = cur_y;
    decision_next = cur_d;
    if (active) begin
      if (cur_d[13]) begin
        decision_next = cur_d + $signed({2'b00, cur_x, 2'b00}) + 14'sd6;
      end else begin
        decision_next = cur_d + $signed({diff_xy[10], diff_xy, 2'b00}) + 14'sd10;
        if (cur_y != 10'd0) begin
          walk_y_next = cur_y - 10'd1;
        end
      end
      walk_x_next = cur_x + 10'd1;
    end

    pt.active = active;
    pt.x = cur_x;
    pt.y = cur_y;
    pt.done = walk_x_next > walk_y_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walk_x <= 10'd0;
      walk_y <= 10'd0;
      decision <= 14'sd3;
    end else if (step) begin
      walk_x <= walk_x_next;
      walk_y <= walk_y_next;
      decision <= decision_next;
    end
  end

  a_restart_first_step: assert property (@(posedge clk) disable iff (rst)
    step && restart |=> walk_x == 10'd1)
    else $error("walk did not advance to x=1 after restart");

  a_hold_when_idle: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(walk_x) && $stable(walk_y) && $stable(decision))
    else $error("walk state moved without an item");

  a_y_never_grows: assert property (@(posedge clk) disable iff (rst)
    step && !restart |=> walk_y <= $past(walk_y))
    else $error("walk_y increased without restart");

endmodule

// ===== hdl/arc_quadrant_rasterizer_top.sv =====
`timescale 1ns / 1ps
// Midpoint circle rasterizer for one quadrant of an arc. Each accepted item runs one
// iteration of the walk and yields one result with two mirrored pixels, each with its
// own valid bit after the x-offset window and the screen clip; arc_done rises once the
// walk has passed the diagonal, and restart begins a new walk at x=0, y=radius. An item
// is accepted every clock unless in_stall is high; the walk update and the pixel clip sit
// between the walk state registers and a single result register, so results appear in
// the cycle after their item, and a new item is taken while the previous result is held,
// as long as that result is taken in the same cycle. The cfg port is always ready; the
// user must write configuration only while no item is in flight; the block doesn't check.
module arc_quadrant_rasterizer_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        restart,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        first_valid,
  output logic [9:0]  first_x,
  output logic [9:0]  first_y,
  output logic        second_valid,
  output logic [9:0]  second_x,
  output logic [9:0]  second_y,
  output logic [31:0] pixel_color,
  output logic        arc_done
);
  import acr_pkg::*;

  logic signed [10:0] center_x;
  logic signed [10:0] center_y;
  logic [8:0]         arc_radius;
  logic [1:0]         quadrant_sel;
  logic signed [9:0]  offset_min;
  logic signed [9:0]  offset_max;
  logic [31:0]        draw_color;

  acr_walk_t          pt;
  logic               accept;
  logic signed [10:0] px;
  logic signed [10:0] py;
  logic signed [10:0] a_dx;
  logic signed [10:0] a_dy;
  logic signed [10:0] b_dx;
  logic signed [10:0] b_dy;
  logic               a_valid;
  logic [9:0]         a_x;
  logic [9:0]         a_y;
  logic               b_valid;
  logic [9:0]         b_x;
  logic [9:0]         b_y;

  assign cfg_ready = 1'b1;
  assign in_stall = out_valid && out_stall;
  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= 11'sd0;
      center_y <= 11'sd0;
      arc_radius <= 9'd0;
      quadrant_sel <= QUAD_UPPER_RIGHT;
      offset_min <= -10'sd512;
      offset_max <= 10'sd511;
      draw_color <= 32'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CENTER_X:     center_x <= $signed(cfg_data[10:0]);
        CFG_CENTER_Y:     center_y <= $signed(cfg_data[10:0]);
        CFG_ARC_RADIUS:   arc_radius <= cfg_data[8:0];
        CFG_QUADRANT_SEL: quadrant_sel <= cfg_data[1:0];
        CFG_OFFSET_MIN:   offset_min <= $signed(cfg_data[9:0]);
        CFG_OFFSET_MAX:   offset_max <= $signed(cfg_data[9:0]);
        CFG_DRAW_COLOR:   draw_color <= cfg_data;
        default: ;
      endcase
    end
  end

  acr_walk u_walk (
    .clk        (clk),
    .rst        (rst),
    .step       (accept),
    .restart    (restart),
    .arc_radius (arc_radius),
    .pt         (pt)
  );

  // mirror the walk point into the selected quadrant
  always_comb begin
    px = $signed({1'b0, pt.x});
    py = $signed({1'b0, pt.y});
    case (quadrant_sel)
      QUAD_UPPER_RIGHT: begin
        a_dx = px;  a_dy = -py; b_dx = py;  b_dy = -px;
      end
      QUAD_UPPER_LEFT: begin
        a_dx = -px; a_dy = -py; b_dx = -py; b_dy = -px;
      end
      QUAD_LOWER_LEFT: begin
        a_dx = -px; a_dy = py;  b_dx = -py; b_dy = px;
      end
      default: begin
        a_dx = px;  a_dy = py;  b_dx = py;  b_dy = px;
      end
    endcase
  end

  acr_place u_place_first (
    .center_x   (center_x),
    .center_y   (center_y),
    .offset_min (offset_min),
    .offset_max (offset_max),
    .enable     (pt.active),
    .dx         (a_dx),
    .dy         (a_dy),
    .pix_valid  (a_valid),
    .pix_x      (a_x),
    .pix_y      (a_y)
  );

  acr_place u_place_second (
    .center_x   (center_x),
    .center_y   (center_y),
    .offset_min (offset_min),
    .offset_max (offset_max),
    .enable     (pt.active),
    .dx         (b_dx),
    .dy         (b_dy),
    .pix_valid  (b_valid),
    .pix_x      (b_x),
    .pix_y      (b_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      first_valid <= a_valid;
      first_x <= a_x;
      first_y <= a_y;
      second_valid <= b_valid;
      second_x <= b_x;
      second_y <= b_y;
      pixel_color <= draw_color | ALPHA_OPAQUE;
      arc_done <= pt.done;
    end
  end

  a_result_follows_item: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted item produced no result");

  a_first_on_screen: assert property (@(posedge clk) disable iff (rst)
    out_valid && first_valid |-> first_x < SCREEN_WIDTH && first_y < SCREEN_HEIGHT)
    else $error("first pixel outside screen");

  a_dropped_pixels_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !second_valid |-> second_x == 10'd0 && second_y == 10'd0)
    else $error("dropped second pixel carries coordinates");

endmodule

// ===== tb/tb_arc_quadrant_rasterizer_top.sv =====
`timescale 1ns / 1ps
module tb_arc_quadrant_rasterizer_top;
  import acr_pkg::*;

  localparam int          STALL_LIMIT = 4000;
  localparam int          ITEM_TARGET = 550;
  localparam logic [2:0]  CFG_UNUSED  = 3'd7;

  typedef struct packed {
    logic       vld;
    logic [9:0] x;
    logic [9:0] y;
  } pixel_t;

  typedef struct {
    pixel_t      first;
    pixel_t      second;
    logic [31:0] color;
    logic        done;
  } pixel_pair_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        restart = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        first_valid;
  logic [9:0]  first_x;
  logic [9:0]  first_y;
  logic        second_valid;
  logic [9:0]  second_x;
  logic [9:0]  second_y;
  logic [31:0] pixel_color;
  logic        arc_done;

  // shadow of the configuration registers
  logic signed [10:0] ctr_x = '0;
  logic signed [10:0] ctr_y = '0;
  logic [8:0]         radius = '0;
  logic [1:0]         quad = QUAD_UPPER_RIGHT;
  logic signed [9:0]  off_min = -10'sd512;
  logic signed [9:0]  off_max = 10'sd511;
  logic [31:0]        color = '0;

  // shadow of the walk state
  logic [9:0]         wx = '0;
  logic [9:0]         wy = '0;
  logic signed [13:0] dec = 14'sd3;

  logic        restart_flags[$];
  pixel_pair_t pixel_pairs_due[$];

  int   send_idle_pct = 0;
  int   stall_pct = 0;
  int   idle_cycles = 0;
  int   items_queued = 0;
  logic failed = 1'b0;

  arc_quadrant_rasterizer_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .restart      (restart),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .first_valid  (first_valid),
    .first_x      (first_x),
    .first_y      (first_y),
    .second_valid (second_valid),
    .second_x     (second_x),
    .second_y     (second_y),
    .pixel_color  (pixel_color),
    .arc_done     (arc_done)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // window test on the x offset, then clamp at zero and clip to the screen
  function automatic pixel_t clip_pixel(input int dx, input int dy);
    pixel_t p;
    int     sx;
    int     sy;
    p = '0;
    if (dx < int'(off_min) || dx > int'(off_max)) return p;
    sx = int'(ctr_x) + dx;
    sy = int'(ctr_y) + dy;
    if (sx < 0) sx = 0;
    if (sy < 0) sy = 0;
    if (sx >= int'(SCREEN_WIDTH) || sy >= int'(SCREEN_HEIGHT)) return p;
    p.vld = 1'b1;
    p.x   = sx[9:0];
    p.y   = sy[9:0];
    return p;
  endfunction

  function automatic pixel_pair_t advance_walk(input logic restart_item);
    pixel_pair_t r;
    int          x;
    int          y;
    int          ax;
    int          ay;
    int          bx;
    int          by;
    int          dnext;
    if (restart_item) begin
      wx    = '0;
      wy    = {1'b0, radius};
      dnext = 3 - 2 * int'(radius);
      dec   = dnext[13:0];
    end
    r.first  = '0;
    r.second = '0;
    r.color  = color | ALPHA_OPAQUE;
    if (wx <= wy) begin
      x = int'(wx);
      y = int'(wy);
      case (quad)
        QUAD_UPPER_RIGHT: begin ax = x;  ay = -y; bx = y;  by = -x; end
        QUAD_UPPER_LEFT:  begin ax = -x; ay = -y; bx = -y; by = -x; end
        QUAD_LOWER_LEFT:  begin ax = -x; ay = y;  bx = -y; by = x;  end
        default:          begin ax = x;  ay = y;  bx = y;  by = x;  end
      endcase
      r.first  = clip_pixel(ax, ay);
      r.second = clip_pixel(bx, by);
      if (dec[13]) begin
        dnext = int'(dec) + 4 * x + 6;
      end else begin
        dnext = int'(dec) + 4 * (x - y) + 10;
        if (wy > 0) wy = wy - 10'd1;
      end
      dec = dnext[13:0];
      wx  = wx + 10'd1;
    end
    r.done = (wx > wy);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      failed = 1'b1;
    end
  endtask

  // driver: one item per accept, sender gaps drawn per cycle
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      restart  <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) pixel_pairs_due.push_back(advance_walk(restart));
      if (restart_flags.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        restart  <= restart_flags.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    pixel_pair_t e;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pixel_pairs_due.size() == 0) begin
          $error("result with no item outstanding");
          failed = 1'b1;
        end else begin
          e = pixel_pairs_due.pop_front();
          check_field("first_valid", 32'(e.first.vld), 32'(first_valid));
          check_field("first_x", 32'(e.first.x), 32'(first_x));
          check_field("first_y", 32'(e.first.y), 32'(first_y));
          check_field("second_valid", 32'(e.second.vld), 32'(second_valid));
          check_field("second_x", 32'(e.second.x), 32'(second_x));
          check_field("second_y", 32'(e.second.y), 32'(second_y));
          check_field("pixel_color", e.color, pixel_color);
          check_field("arc_done", 32'(e.done), 32'(arc_done));
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // watchdog on cycles with no transfer at all
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_arc_quadrant_rasterizer_top NOT OK");
      $finish;
    end
  end

  // leaves cfg_valid high; caller lowers it after the last write
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_CENTER_X:     ctr_x   = data[10:0];
      CFG_CENTER_Y:     ctr_y   = data[10:0];
      CFG_ARC_RADIUS:   radius  = data[8:0];
      CFG_QUADRANT_SEL: quad    = data[1:0];
      CFG_OFFSET_MIN:   off_min = data[9:0];
      CFG_OFFSET_MAX:   off_max = data[9:0];
      CFG_DRAW_COLOR:   color   = data;
      default: ;
    endcase
  endtask

  // junk above the register width half of the time
  function automatic logic [31:0] pad(input int value, input int width);
    logic [31:0] mask;
    logic [31:0] v;
    mask = (32'd1 << width) - 32'd1;
    v    = value;
    if ($urandom_range(1) == 1) return ($urandom() & ~mask) | (v & mask);
    return v & mask;
  endfunction

  task automatic program_arc(input int cx, input int cy, input int r, input int q,
                             input int omin, input int omax, input logic [31:0] c);
    write_reg(CFG_CENTER_X, pad(cx, 11));
    write_reg(CFG_CENTER_Y, pad(cy, 11));
    write_reg(CFG_ARC_RADIUS, pad(r, 9));
    write_reg(CFG_QUADRANT_SEL, pad(q, 2));
    write_reg(CFG_OFFSET_MIN, pad(omin, 10));
    write_reg(CFG_OFFSET_MAX, pad(omax, 10));
    write_reg(CFG_DRAW_COLOR, c);
    if ($urandom_range(9) == 0) write_reg(CFG_UNUSED, $urandom());
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_walk(input int n, input logic first_restart, input int noise_pct);
    restart_flags.push_back(first_restart);
    for (int i = 1; i < n; i++) restart_flags.push_back($urandom_range(99) < noise_pct);
    items_queued += n;
  endtask

  task automatic wait_drained();
    while (restart_flags.size() != 0 || in_valid || pixel_pairs_due.size() != 0)
      @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  initial begin
    int phase;
    int r;
    int n;
    int cx;
    int cy;
    int omin;
    int omax;
    int t;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // walk straight out of reset: zero radius at the origin
    queue_walk(2, 1'b0, 0);
    wait_drained();
    program_arc(1023, -1024, 511, QUAD_LOWER_RIGHT, -512, 511, 32'h0000_0000);
    queue_walk(2, 1'b1, 0);
    wait_drained();
    program_arc(-1024, 1023, 511, QUAD_UPPER_LEFT, -512, 511, 32'hFFFF_FFFF);
    queue_walk(2, 1'b1, 0);
    wait_drained();
    // zero radius: centre pixel twice, then the walk is over
    program_arc(240, 136, 0, QUAD_LOWER_LEFT, -512, 511, 32'h1234_5678);
    queue_walk(3, 1'b1, 0);
    wait_drained();
    // negative screen coordinates clamp to zero, narrow window
    program_arc(2, 3, 6, QUAD_UPPER_RIGHT, -1, 4, 32'h00AB_CDEF);
    queue_walk(7, 1'b1, 0);
    wait_drained();
    // pixels past the right and bottom edges are dropped
    program_arc(478, 270, 5, QUAD_LOWER_RIGHT, 0, 0, 32'h8000_0001);
    queue_walk(5, 1'b1, 0);
    wait_drained();
    // empty window
    program_arc(100, 100, 4, QUAD_UPPER_LEFT, 511, -512, 32'h7F00_FF00);
    queue_walk(3, 1'b1, 0);
    wait_drained();

    phase = 0;
    while (items_queued < ITEM_TARGET) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 47; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 47; end
        default: begin send_idle_pct = 26; stall_pct = 26; end
      endcase
      t = $urandom_range(99);
      if (t < 4) r = $urandom_range(511, 400);
      else if (t < 20) r = $urandom_range(150, 41);
      else r = $urandom_range(40, 0);
      if ($urandom_range(9) < 7) begin
        cx = $urandom_range(540, 0) - 60;
        cy = $urandom_range(330, 0) - 60;
      end else begin
        cx = $urandom_range(2047, 0) - 1024;
        cy = $urandom_range(2047, 0) - 1024;
      end
      t = $urandom_range(9);
      if (t < 7) begin
        omin = -512;
        omax = 511;
      end else if (t < 9) begin
        omin = $urandom_range(1023, 0) - 512;
        omax = $urandom_range(511 - omin, 0) + omin;
      end else begin
        omin = $urandom_range(1023, 0) - 512;
        omax = $urandom_range(1023, 0) - 512;
      end
      program_arc(cx, cy, r, $urandom_range(3), omin, omax, $urandom());
      n = r * 707 / 1000 + 2 + $urandom_range(3);
      // now and then carry on the previous walk under the new settings
      queue_walk(n, $urandom_range(9) != 0, 6);
      wait_drained();
      phase++;
    end

    send_idle_pct = 0;
    stall_pct = 0;
    wait_drained();
    repeat (5) @(posedge clk);
    if (!failed) begin
      $display("tb_arc_quadrant_rasterizer_top OK");
    end else begin
      $display("tb_arc_quadrant_rasterizer_top NOT OK");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/acr_pkg.sv
hdl/acr_place.sv
hdl/acr_walk.sv
hdl/arc_quadrant_rasterizer_top.sv
tb/tb_arc_quadrant_rasterizer_top.sv
